>>> rtl/ccc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types, codes and defaults of the CNF clause conditioner.
// ----------------------------------------------------------------------------
package ccc_pkg;

    localparam int VAR_W              = 10;
    localparam int DEF_NUM_VARS       = 1024;
    localparam int DEF_MAX_CLAUSE_LEN = 32;

    // operation codes of an input item
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_ASSIGN  = 2'd1;
    localparam logic [1:0] OP_LITERAL = 2'd2;

    // assignment store codes
    localparam logic [1:0] ASG_NONE = 2'd0;
    localparam logic [1:0] ASG_POS  = 2'd1;
    localparam logic [1:0] ASG_NEG  = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [VAR_W-1:0] var_index;
        logic             negated;
        logic             is_hard;
        logic             clause_end;
    } t_in_item;

    typedef struct packed {
        logic [VAR_W-1:0] out_var;
        logic             out_negated;
        logic             out_hard;
        logic             out_last;
        logic             empty_clause;
        logic             overflow;
    } t_out_item;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_ASSIGN,
        K_LITERAL
    } t_kind;

    // classified command passed from front to back
    typedef struct packed {
        t_kind            kind;
        logic [VAR_W-1:0] var_index;
        logic             negated;
        logic             is_hard;
        logic             clause_end;
        logic             in_range;
    } t_cmd;

    // queue handshake between front and back
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_out;

    typedef struct packed {
        logic ready;
        logic clearing;
    } t_back_status;

endpackage

>>> rtl/ccc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_front
// Accepts input items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module ccc_front #(
    parameter int NUM_VARS = ccc_pkg::DEF_NUM_VARS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ccc_pkg::t_in_item     i_in_data,
    output ccc_pkg::t_queue_out   o_queue,
    input  ccc_pkg::t_back_status i_status
);
    import ccc_pkg::*;

    localparam int QD   = 2;
    localparam int PW   = $clog2(QD);
    localparam int CNTW = $clog2(QD + 1);

    t_cmd            r_q [QD];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CNTW-1:0] r_cnt;

    t_cmd cls;
    logic is_cmd;
    logic push;
    logic pop;

    always_comb begin
        cls.var_index  = i_in_data.var_index;
        cls.negated    = i_in_data.negated;
        cls.is_hard    = i_in_data.is_hard;
        cls.clause_end = i_in_data.clause_end;
        cls.in_range   = (32'(i_in_data.var_index) < 32'(NUM_VARS));
        is_cmd         = 1'b1;
        case (i_in_data.operation)
            OP_CLEAR:   cls.kind = K_CLEAR;
            OP_ASSIGN:  cls.kind = K_ASSIGN;
            OP_LITERAL: cls.kind = K_LITERAL;
            default: begin
                // unused code: taken and dropped
                cls.kind = K_CLEAR;
                is_cmd   = 1'b0;
            end
        endcase
    end

    assign o_in_ready    = (r_cnt != CNTW'(QD)) && !i_status.clearing;
    assign push          = i_in_valid && o_in_ready && is_cmd;
    assign o_queue.valid = (r_cnt != '0);
    assign o_queue.cmd   = r_q[r_rp];
    assign pop           = o_queue.valid && i_status.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(QD - 1)) ? '0 : r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(QD - 1)) ? '0 : r_rp + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

>>> rtl/ccc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_back
// Executes queued commands: assignment store, clause buffer and emission.
// ----------------------------------------------------------------------------
module ccc_back #(
    parameter int NUM_VARS       = ccc_pkg::DEF_NUM_VARS,
    parameter int MAX_CLAUSE_LEN = ccc_pkg::DEF_MAX_CLAUSE_LEN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ccc_pkg::t_queue_out   i_queue,
    output ccc_pkg::t_back_status o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ccc_pkg::t_out_item    o_out_data
);
    import ccc_pkg::*;

    localparam int STORE_DEPTH = (NUM_VARS < (1 << VAR_W)) ? NUM_VARS : (1 << VAR_W);
    localparam int SA_W        = $clog2(STORE_DEPTH);
    localparam int BA_W        = $clog2(MAX_CLAUSE_LEN);
    localparam int CW          = $clog2(MAX_CLAUSE_LEN + 1);
    localparam int BUF_W       = VAR_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UNIT,
        S_LOOK,
        S_PRIME,
        S_EMIT,
        S_EMPTY
    } t_state;

    t_state          r_state, n_state;
    logic [SA_W-1:0] r_sweep, n_sweep;
    t_cmd            r_cmd, n_cmd;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_sat, n_sat;
    logic            r_ovf, n_ovf;
    logic            r_hard, n_hard;
    logic            r_out_valid;
    t_out_item       r_out, n_out;
    logic            load;

    logic [1:0]       r_asg_mem [STORE_DEPTH];
    logic [1:0]       r_asg_q;
    logic             asg_we;
    logic [SA_W-1:0]  asg_waddr;
    logic [1:0]       asg_wdata;
    logic [SA_W-1:0]  asg_raddr;

    logic [BUF_W-1:0] r_buf_mem [MAX_CLAUSE_LEN];
    logic [BUF_W-1:0] r_buf_q;
    logic             buf_we;
    logic [BA_W-1:0]  buf_waddr;
    logic [BUF_W-1:0] buf_wdata;
    logic [BA_W-1:0]  buf_raddr;

    logic       slot_free;
    logic [1:0] lit_val;
    logic [1:0] lit_code;

    assign slot_free         = !r_out_valid || i_out_ready;
    assign o_status.ready    = (r_state == S_IDLE);
    assign o_status.clearing = (r_state == S_CLEAR);
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

    assign asg_raddr = i_queue.cmd.var_index[SA_W-1:0];
    assign buf_waddr = r_count[BA_W-1:0];
    assign buf_wdata = {r_cmd.negated, r_cmd.var_index};
    assign buf_raddr = n_idx[BA_W-1:0];
    assign lit_val   = r_cmd.in_range ? r_asg_q : ASG_NONE;
    assign lit_code  = r_cmd.negated ? ASG_NEG : ASG_POS;

    always_comb begin
        n_state   = r_state;
        n_sweep   = r_sweep;
        n_cmd     = r_cmd;
        n_count   = r_count;
        n_idx     = r_idx;
        n_sat     = r_sat;
        n_ovf     = r_ovf;
        n_hard    = r_hard;
        n_out     = '0;
        load      = 1'b0;
        asg_we    = 1'b0;
        asg_waddr = i_queue.cmd.var_index[SA_W-1:0];
        asg_wdata = i_queue.cmd.negated ? ASG_NEG : ASG_POS;
        buf_we    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                asg_we    = 1'b1;
                asg_waddr = r_sweep;
                asg_wdata = ASG_NONE;
                n_sweep   = r_sweep + SA_W'(1);
                if (r_sweep == SA_W'(STORE_DEPTH - 1)) begin
                    n_sweep = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_queue.valid) begin
                    n_cmd = i_queue.cmd;
                    case (i_queue.cmd.kind)
                        K_CLEAR:   n_state = S_CLEAR;
                        K_ASSIGN: begin
                            asg_we  = i_queue.cmd.in_range;
                            n_state = S_UNIT;
                        end
                        K_LITERAL: n_state = S_LOOK;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_UNIT: begin
                if (slot_free) begin
                    load              = 1'b1;
                    n_out.out_var     = r_cmd.var_index;
                    n_out.out_negated = r_cmd.negated;
                    n_out.out_last    = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_LOOK: begin
                if (!r_sat) begin
                    if (lit_val == ASG_NONE) begin
                        if (r_count != CW'(MAX_CLAUSE_LEN)) begin
                            buf_we  = 1'b1;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (lit_val == lit_code) begin
                        n_sat = 1'b1;
                    end
                end
                n_state = S_IDLE;
                if (r_cmd.clause_end) begin
                    n_hard = r_cmd.is_hard;
                    n_idx  = '0;
                    if (n_sat) begin
                        n_count = '0;
                        n_sat   = 1'b0;
                        n_ovf   = 1'b0;
                    end else if (n_count == '0) begin
                        n_state = S_EMPTY;
                    end else begin
                        // S_PRIME covers the buffer read of entry zero
                        n_state = S_PRIME;
                    end
                end
            end
            S_PRIME: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    load              = 1'b1;
                    n_out.out_var     = r_buf_q[VAR_W-1:0];
                    n_out.out_negated = r_buf_q[VAR_W];
                    n_out.out_hard    = r_hard;
                    n_out.out_last    = ((r_idx + CW'(1)) == r_count);
                    n_out.overflow    = r_ovf;
                    n_idx             = r_idx + CW'(1);
                    if (n_out.out_last) begin
                        n_idx   = '0;
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMPTY: begin
                if (slot_free) begin
                    load               = 1'b1;
                    n_out.out_hard     = r_hard;
                    n_out.out_last     = 1'b1;
                    n_out.empty_clause = 1'b1;
                    n_count            = '0;
                    n_ovf              = 1'b0;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_sat       <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_sat   <= n_sat;
            r_ovf   <= n_ovf;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_cmd  <= n_cmd;
        r_hard <= n_hard;
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (asg_we) begin
            r_asg_mem[asg_waddr] <= asg_wdata;
        end
        r_asg_q <= r_asg_mem[asg_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_buf_mem[buf_waddr] <= buf_wdata;
        end
        r_buf_q <= r_buf_mem[buf_raddr];
    end

endmodule

>>> rtl/cnf_clause_conditioner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnf_clause_conditioner_top
// Conditions a streamed CNF formula on a partial assignment of its variables.
// ----------------------------------------------------------------------------
// a clause literal is handled in the back end by a store read, then a decision in S_LOOK
// an assign item writes the store as it leaves the queue; S_UNIT then emits its unit clause
// after the S_PRIME buffer read a clause goes out 1 literal per cycle unless stalled
// a clear item sweeps all min(NUM_VARS, 1024) entries of the assignment store
// after reset the same sweep runs with the input held not ready
// the 2-entry queue takes input while the back end is busy, but not during a clear sweep
module cnf_clause_conditioner_top #(
    parameter int NUM_VARS       = ccc_pkg::DEF_NUM_VARS,
    parameter int MAX_CLAUSE_LEN = ccc_pkg::DEF_MAX_CLAUSE_LEN
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ccc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ccc_pkg::t_out_item o_out_data
);
    import ccc_pkg::*;

    t_queue_out   queue;
    t_back_status status;

    ccc_front #(
        .NUM_VARS (NUM_VARS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_queue    (queue),
        .i_status   (status)
    );

    ccc_back #(
        .NUM_VARS       (NUM_VARS),
        .MAX_CLAUSE_LEN (MAX_CLAUSE_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_queue     (queue),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/ccc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_checker
// Port-level checks of the clause conditioner, bound to the top level.
// ----------------------------------------------------------------------------
module ccc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input ccc_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ccc_pkg::t_out_item o_out_data
);
    import ccc_pkg::*;

    // a stalled result transfer holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // the empty-clause marker is a lone, clean, last item
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.empty_clause |->
            o_out_data.out_last && !o_out_data.overflow &&
            !o_out_data.out_negated && (o_out_data.out_var == '0))
        else $error("malformed empty-clause marker");

    // no result and no input transfer in the first cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out_valid && !o_in_ready)
        else $error("activity right after reset");

    // overflow never rides on the empty-clause marker
    a_ovf_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overflow |-> !o_out_data.empty_clause)
        else $error("overflow flag on empty-clause marker");

endmodule

bind cnf_clause_conditioner_top ccc_checker u_ccc_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CNF clause conditioner. Directed clauses cover
// unit clauses, satisfied and falsified literals, empty clauses, clears and
// unused codes. Random formula phases then stream well-formed clauses with
// noise items mixed in, under changing idle patterns on both sides. Every
// result is checked in order against a local model of the conditioning.
// ----------------------------------------------------------------------------
module tb;
    import ccc_pkg::*;

    localparam int          CLK_PERIOD     = 20;
    localparam int          MAX_LEN        = DEF_MAX_CLAUSE_LEN;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          DRAIN_CYCLES   = 1100;
    localparam int          PHASE_ITEMS    = 100;
    localparam int          MAX_REPORTS    = 10;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    // model state of the conditioning
    logic [1:0]        asg_table [DEF_NUM_VARS];
    logic [VAR_W:0]    kept_buf [MAX_LEN];
    int                kept_count;
    logic              clause_sat;
    logic              clause_ovf;
    t_out_item         expected_lits [$];

    int send_idle_pct;
    int recv_idle_pct;
    int n_items;
    int n_results;
    int n_empty;
    int n_ovf_lits;
    int n_mismatch;
    int idle_cycles;

    cnf_clause_conditioner_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic t_in_item mk_item(input logic [1:0] op, input logic [VAR_W-1:0] v,
                                         input logic neg, input logic hard,
                                         input logic last);
        t_in_item it;
        it.operation  = op;
        it.var_index  = v;
        it.negated    = neg;
        it.is_hard    = hard;
        it.clause_end = last;
        return it;
    endfunction

    function automatic t_out_item mk_lit(input logic [VAR_W-1:0] v, input logic neg,
                                         input logic hard, input logic last,
                                         input logic empty, input logic ovf);
        t_out_item r;
        r.out_var      = v;
        r.out_negated  = neg;
        r.out_hard     = hard;
        r.out_last     = last;
        r.empty_clause = empty;
        r.overflow     = ovf;
        return r;
    endfunction

    function automatic void queue_result(input t_out_item r);
        expected_lits = {expected_lits, r};
    endfunction

    function automatic string fmt_res(input t_out_item r);
        return $sformatf("var=%0d neg=%b hard=%b last=%b empty=%b ovf=%b",
                         r.out_var, r.out_negated, r.out_hard, r.out_last,
                         r.empty_clause, r.overflow);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    // a small pool of often-assigned variables with pool_pct percent chance, else the full range
    function automatic logic [VAR_W-1:0] pick_var(input int pool_pct);
        if ($urandom_range(99) < pool_pct)
            return VAR_W'($urandom_range(15));
        return VAR_W'($urandom_range(DEF_NUM_VARS - 1));
    endfunction

    // conditions one accepted item and queues the literals it emits
    task automatic condition_item(input t_in_item it);
        logic [1:0] stored;
        logic [1:0] agree;
        agree = it.negated ? ASG_NEG : ASG_POS;
        case (it.operation)
            OP_CLEAR: begin
                foreach (asg_table[v]) asg_table[v] = ASG_NONE;
            end
            OP_ASSIGN: begin
                asg_table[it.var_index] = agree;
                queue_result(mk_lit(it.var_index, it.negated, 1'b0, 1'b1, 1'b0, 1'b0));
            end
            OP_LITERAL: begin
                if (!clause_sat) begin
                    stored = asg_table[it.var_index];
                    if (stored == ASG_NONE) begin
                        if (kept_count < MAX_LEN) begin
                            kept_buf[kept_count] = {it.negated, it.var_index};
                            kept_count++;
                        end else begin
                            clause_ovf = 1'b1;
                        end
                    end else if (stored == agree) begin
                        clause_sat = 1'b1;
                    end
                end
                if (it.clause_end) begin
                    if (!clause_sat && kept_count == 0) begin
                        queue_result(mk_lit('0, 1'b0, it.is_hard, 1'b1, 1'b1, 1'b0));
                        n_empty++;
                    end else if (!clause_sat) begin
                        for (int k = 0; k < kept_count; k++) begin
                            queue_result(mk_lit(kept_buf[k][VAR_W-1:0],
                                                kept_buf[k][VAR_W], it.is_hard,
                                                k == kept_count - 1, 1'b0,
                                                clause_ovf));
                            if (clause_ovf) n_ovf_lits++;
                        end
                    end
                    kept_count = 0;
                    clause_sat = 1'b0;
                    clause_ovf = 1'b0;
                end
            end
            default: begin
            end
        endcase
    endtask

    // holds valid until the transfer, idling beforehand at random
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        condition_item(it);
        if (it.operation != OP_UNUSED) n_items++;
    endtask

    task automatic send_random_clause(input logic force_long);
        int   len;
        int   pool_pct;
        logic hard;
        if (force_long || $urandom_range(99) < 8) begin
            len      = $urandom_range(MAX_LEN + 3, MAX_LEN - 1);
            pool_pct = 3;
        end else begin
            len      = $urandom_range(6, 1);
            pool_pct = 60;
        end
        for (int k = 0; k < len; k++) begin
            // an occasional assign or unused code inside a clause
            if ($urandom_range(99) < 4)
                send_item(mk_item(rand_bit() ? OP_ASSIGN : OP_UNUSED, pick_var(60),
                                  rand_bit(), rand_bit(), rand_bit()));
            hard = rand_bit();
            send_item(mk_item(OP_LITERAL, pick_var(pool_pct), rand_bit(), hard,
                              k == len - 1));
        end
    endtask

    task automatic test_unit_clauses;
        send_item(mk_item(OP_ASSIGN, 10'd0, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(OP_ASSIGN, 10'd1023, 1'b1, 1'b0, 1'b1));
        send_item(mk_item(OP_ASSIGN, 10'd512, 1'b0, 1'b1, 1'b1));
    endtask

    task automatic test_clause_filtering;
        // falsified literal dropped, tag taken from the clause end
        send_item(mk_item(OP_LITERAL, 10'd5, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(OP_LITERAL, 10'd1023, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(OP_LITERAL, 10'd7, 1'b1, 1'b1, 1'b1));
        // every literal falsified gives the empty-clause marker
        send_item(mk_item(OP_LITERAL, 10'd0, 1'b1, 1'b1, 1'b0));
        send_item(mk_item(OP_LITERAL, 10'd1023, 1'b0, 1'b0, 1'b1));
        // satisfied in the middle, the rest ignored
        send_item(mk_item(OP_LITERAL, 10'd9, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(OP_LITERAL, 10'd0, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(OP_LITERAL, 10'd11, 1'b1, 1'b1, 1'b1));
        send_item(mk_item(OP_LITERAL, 10'd300, 1'b1, 1'b1, 1'b1));
        // a later assign overrides the earlier polarity
        send_item(mk_item(OP_ASSIGN, 10'd512, 1'b1, 1'b0, 1'b0));
        send_item(mk_item(OP_LITERAL, 10'd512, 1'b1, 1'b0, 1'b1));
        send_item(mk_item(OP_LITERAL, 10'd512, 1'b0, 1'b1, 1'b1));
    endtask

    task automatic test_clear_and_noise;
        send_item(mk_item(OP_UNUSED, 10'd1023, 1'b1, 1'b1, 1'b1));
        send_item(mk_item(OP_CLEAR, 10'd0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(OP_LITERAL, 10'd0, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(OP_LITERAL, 10'd1023, 1'b1, 1'b1, 1'b1));
        // a clear inside a clause keeps what is buffered
        send_item(mk_item(OP_ASSIGN, 10'd4, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(OP_LITERAL, 10'd3, 1'b1, 1'b0, 1'b0));
        send_item(mk_item(OP_CLEAR, 10'd0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(OP_LITERAL, 10'd4, 1'b1, 1'b0, 1'b1));
    endtask

    task automatic test_random_formula(input int budget);
        int start;
        int pick;
        start = n_items;
        send_random_clause(1'b1);
        while (n_items - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 3)
                send_item(mk_item(OP_CLEAR, pick_var(0), rand_bit(),
                                  rand_bit(), rand_bit()));
            else if (pick < 18)
                send_item(mk_item(OP_ASSIGN, pick_var(80), rand_bit(),
                                  rand_bit(), rand_bit()));
            else if (pick < 21)
                send_item(mk_item(OP_UNUSED, pick_var(0), rand_bit(),
                                  rand_bit(), rand_bit()));
            else
                send_random_clause(1'b0);
        end
    endtask

    task automatic drain_results;
        in_valid <= 1'b0;
        while (expected_lits.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // result checker and receiver stalls
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                n_results++;
                if (expected_lits.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("unexpected result: %s", fmt_res(out_data));
                end else begin
                    want = expected_lits.pop_front();
                    if (out_data.out_var !== want.out_var ||
                        out_data.out_negated !== want.out_negated ||
                        out_data.out_hard !== want.out_hard ||
                        out_data.out_last !== want.out_last ||
                        out_data.empty_clause !== want.empty_clause ||
                        out_data.overflow !== want.overflow) begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_REPORTS) begin
                            $display("result %0d expected: %s", n_results, fmt_res(want));
                            $display("result %0d actual:   %s", n_results,
                                     fmt_res(out_data));
                        end
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", idle_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        foreach (asg_table[v]) asg_table[v] = ASG_NONE;
        kept_count    = 0;
        clause_sat    = 1'b0;
        clause_ovf    = 1'b0;
        n_items       = 0;
        n_results     = 0;
        n_empty       = 0;
        n_ovf_lits    = 0;
        n_mismatch    = 0;
        idle_cycles   = 0;
        send_idle_pct = 10;
        recv_idle_pct = 85;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_unit_clauses();
        test_clause_filtering();
        test_clear_and_noise();
        test_random_formula(PHASE_ITEMS);
        send_idle_pct = 85;
        recv_idle_pct = 10;
        test_random_formula(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_formula(PHASE_ITEMS);
        drain_results();

        $display("covered %0d input items and %0d results under three idle patterns",
                 n_items, n_results);
        $display("results included %0d empty-clause markers and %0d overflow literals",
                 n_empty, n_ovf_lits);
        if (n_mismatch == 0 && expected_lits.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
